>>> sv/bfa_pkg.sv
// Shared constants, codes and control types of the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int DEF_FRAME_COUNT = 4096;
    localparam int DEF_FRAME_BYTES = 4096;

    localparam int WORD_BITS  = 32;
    localparam int WORD_SH    = 5;
    localparam int CHUNK_BITS = 8;
    localparam int CHUNK_SH   = 3;
    localparam int CHUNKS     = WORD_BITS / CHUNK_BITS;

    localparam int CFG_W      = 13;
    localparam int CMD_W      = 3;
    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 13;
    localparam int OUT_ADDR_W = 24;
    localparam int WIDE_W     = 50;

    localparam logic [CMD_W-1:0] CMD_INIT          = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MARK_USABLE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK_RESERVED = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALLOC         = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FREE          = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_CLAMP,
        ST_DISPATCH,
        ST_INIT_SWEEP,
        ST_SPAN_RD,
        ST_SPAN_WR,
        ST_SCAN_RD,
        ST_SCAN_BIT,
        ST_ALLOC_SET,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic setup;
        logic clamp;
        logic sweep_start;
        logic sweep_wr;
        logic span_rd;
        logic span_wr;
        logic scan_start;
        logic scan_rd;
        logic scan_step;
        logic alloc_set;
        logic done_ok;
        logic load_out;
    } bfa_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             sweep_last;
        logic             span_empty;
        logic             span_last;
        logic             alloc_bad;
        logic             hit;
        logic             stop;
        logic             chunk_last;
    } bfa_sts_t;

endpackage

>>> sv/bfa_datapath.sv
// Datapath of the bitmap frame allocator: used map memory, span walker, run scanner.
`timescale 1ns / 1ps

module bfa_datapath #(
    parameter int FRAME_COUNT = bfa_pkg::DEF_FRAME_COUNT,
    parameter int FRAME_BYTES = bfa_pkg::DEF_FRAME_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bfa_pkg::bfa_cmd_t                cmd,
    output bfa_pkg::bfa_sts_t                sts,
    input  logic [bfa_pkg::CMD_W-1:0]        command,
    input  logic [bfa_pkg::ADDR_W-1:0]       base_address,
    input  logic [bfa_pkg::ADDR_W-1:0]       length_bytes,
    input  logic [bfa_pkg::CNT_W-1:0]        frame_count,
    input  logic [bfa_pkg::CFG_W-1:0]        managed_frames,
    output logic [bfa_pkg::OUT_ADDR_W-1:0]   frame_address,
    output logic                             success,
    output logic [bfa_pkg::CNT_W-1:0]        free_count,
    output logic [bfa_pkg::CNT_W-1:0]        used_count
);
    import bfa_pkg::*;

    localparam int DEPTH = FRAME_COUNT / WORD_BITS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IDX_W = $clog2(FRAME_COUNT);
    localparam int LIM_W = IDX_W + 1;
    localparam int CW    = (LIM_W > CNT_W) ? LIM_W : CNT_W;
    localparam int SH    = $clog2(FRAME_BYTES);

    // used map, one bit per frame
    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [CMD_W-1:0]  cmd_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] len_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WIDE_W-1:0] first_raw_reg, first_raw_next;
    logic [WIDE_W-1:0] end_raw_reg, end_raw_next;
    logic [LIM_W-1:0]  span_first_reg;
    logic [LIM_W-1:0]  span_end_reg;
    logic              span_empty_reg;
    logic              set_mode_reg;
    logic [AW-1:0]     word_reg;
    logic [1:0]        chunk_reg;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [LIM_W-1:0]  hit_idx_reg;
    logic [CNT_W-1:0]  free_total_reg;
    logic              ok_reg;
    logic [OUT_ADDR_W-1:0] addr_reg;
    logic [OUT_ADDR_W-1:0] frame_address_reg;
    logic                  success_reg;
    logic [CNT_W-1:0]      free_count_reg;
    logic [CNT_W-1:0]      used_count_reg;

    logic [LIM_W-1:0]  lim;
    logic [CW-1:0]     mf_ext;
    logic [WIDE_W-1:0] base_w;
    logic [WIDE_W-1:0] top_w;
    logic [WIDE_W-1:0] fb_m1;
    logic [LIM_W-1:0]  end_c;
    logic              clamp_empty;
    logic [LIM_W-1:0]  first_c;
    logic [LIM_W-1:0]  last_idx;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] new_word;
    logic [5:0]        pop;
    logic [LIM_W-1:0]  bit_idx;
    logic [CHUNK_BITS-1:0] chunk_bits;
    logic [LIM_W-1:0]  chunk_base;
    logic [LIM_W-1:0]  step_idx;
    logic              hit;
    logic [LIM_W-1:0]  hit_idx;
    logic              stop;
    logic [LIM_W-1:0]  alloc_first;
    logic [LIM_W-1:0]  alloc_end;
    logic [47:0]       addr_wide;
    logic [CW-1:0]     used_wide;

    assign mf_ext = CW'(managed_frames);
    assign lim    = (mf_ext < CW'(FRAME_COUNT)) ? LIM_W'(mf_ext) : LIM_W'(FRAME_COUNT);

    // span bounds before clamping
    assign base_w = WIDE_W'(base_reg);
    assign top_w  = base_w + WIDE_W'(len_reg);
    assign fb_m1  = WIDE_W'(FRAME_BYTES - 1);

    always_comb
    begin
        case (cmd_reg)
            CMD_MARK_USABLE:
            begin
                first_raw_next = (base_w + fb_m1) >> SH;
                end_raw_next   = top_w >> SH;
            end
            CMD_MARK_RESERVED:
            begin
                first_raw_next = base_w >> SH;
                end_raw_next   = (top_w + fb_m1) >> SH;
            end
            default:
            begin
                first_raw_next = base_w >> SH;
                end_raw_next   = (base_w >> SH) + WIDE_W'(cnt_reg);
            end
        endcase
    end

    assign end_c       = (end_raw_reg < WIDE_W'(lim)) ? LIM_W'(end_raw_reg) : lim;
    assign clamp_empty = first_raw_reg >= WIDE_W'(end_c);
    assign first_c     = LIM_W'(first_raw_reg);

    // span walker: one word per read/write pair
    assign last_idx = span_end_reg - LIM_W'(1);

    always_comb
    begin
        mask = '0;
        bit_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            bit_idx = LIM_W'({word_reg, WORD_SH'(i)});
            mask[i] = (bit_idx >= span_first_reg) && (bit_idx < span_end_reg);
        end
    end

    assign new_word = set_mode_reg ? (rd_data_reg | mask) : (rd_data_reg & ~mask);
    assign pop      = 6'($countones(new_word ^ rd_data_reg));

    // run scanner: one chunk of frames per cycle, pausing for a read at each new map word
    assign chunk_bits = rd_data_reg[chunk_reg*CHUNK_BITS +: CHUNK_BITS];
    assign chunk_base = LIM_W'({word_reg, chunk_reg, CHUNK_SH'(0)});
    assign stop = (LIM_W+1)'(chunk_base) + (LIM_W+1)'(CHUNK_BITS) >= (LIM_W+1)'(lim);

    always_comb
    begin
        run_next = run_reg;
        hit      = 1'b0;
        hit_idx  = '0;
        step_idx = '0;
        for (int j = 0; j < CHUNK_BITS; j++)
        begin
            step_idx = chunk_base + LIM_W'(j);
            if (!hit && (step_idx < lim))
            begin
                run_next = chunk_bits[j] ? '0 : run_next + CNT_W'(1);
                if (run_next == cnt_reg)
                begin
                    hit     = 1'b1;
                    hit_idx = step_idx;
                end
            end
        end
    end

    assign alloc_end   = hit_idx_reg + LIM_W'(1);
    assign alloc_first = alloc_end - LIM_W'(cnt_reg);
    assign addr_wide   = 48'(alloc_first) << SH;
    assign used_wide   = (CW'(lim) > CW'(free_total_reg)) ?
                         CW'(lim) - CW'(free_total_reg) : '0;

    assign sts.cmd        = cmd_reg;
    assign sts.sweep_last = word_reg == AW'(DEPTH - 1);
    assign sts.span_empty = span_empty_reg;
    assign sts.span_last  = word_reg == last_idx[WORD_SH +: AW];
    assign sts.alloc_bad  = (cnt_reg == '0) || (CW'(cnt_reg) > CW'(lim));
    assign sts.hit        = hit;
    assign sts.stop       = stop;
    assign sts.chunk_last = chunk_reg == 2'(CHUNKS - 1);

    assign mem_we    = cmd.sweep_wr | cmd.span_wr;
    assign mem_re    = cmd.span_rd | cmd.scan_rd;
    assign mem_wdata = cmd.sweep_wr ? '1 : new_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[word_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[word_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg       <= '0;
            chunk_reg      <= '0;
            free_total_reg <= '0;
        end
        else
        begin
            if (cmd.sweep_start || cmd.scan_start)
            begin
                word_reg <= '0;
            end
            else if (cmd.sweep_wr || cmd.span_wr)
            begin
                word_reg <= word_reg + AW'(1);
            end
            else if (cmd.clamp)
            begin
                word_reg <= first_c[WORD_SH +: AW];
            end
            else if (cmd.alloc_set)
            begin
                word_reg <= alloc_first[WORD_SH +: AW];
            end
            else if (cmd.scan_step && !hit && sts.chunk_last)
            begin
                word_reg <= word_reg + AW'(1);
            end

            if (cmd.scan_start)
            begin
                chunk_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                chunk_reg <= chunk_reg + 2'(1);
            end

            if (cmd.sweep_wr)
            begin
                free_total_reg <= '0;
            end
            else if (cmd.span_wr)
            begin
                free_total_reg <= set_mode_reg ? free_total_reg - CNT_W'(pop)
                                               : free_total_reg + CNT_W'(pop);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg  <= command;
            base_reg <= base_address;
            len_reg  <= length_bytes;
            cnt_reg  <= frame_count;
            ok_reg   <= 1'b0;
            addr_reg <= '0;
        end
        if (cmd.setup)
        begin
            first_raw_reg <= first_raw_next;
            end_raw_reg   <= end_raw_next;
            set_mode_reg  <= (cmd_reg == CMD_MARK_RESERVED) || (cmd_reg == CMD_ALLOC);
        end
        if (cmd.clamp)
        begin
            span_first_reg <= first_c;
            span_end_reg   <= end_c;
            span_empty_reg <= clamp_empty;
        end
        if (cmd.scan_start)
        begin
            run_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            run_reg <= run_next;
        end
        if (cmd.scan_step && hit)
        begin
            hit_idx_reg <= hit_idx;
        end
        if (cmd.done_ok)
        begin
            ok_reg <= 1'b1;
        end
        if (cmd.alloc_set)
        begin
            span_first_reg <= alloc_first;
            span_end_reg   <= alloc_end;
            ok_reg         <= 1'b1;
            addr_reg       <= addr_wide[OUT_ADDR_W-1:0];
        end
        if (cmd.load_out)
        begin
            frame_address_reg <= addr_reg;
            success_reg       <= ok_reg;
            free_count_reg    <= free_total_reg;
            used_count_reg    <= CNT_W'(used_wide);
        end
    end

    assign frame_address = frame_address_reg;
    assign success       = success_reg;
    assign free_count    = free_count_reg;
    assign used_count    = used_count_reg;

`ifndef SYNTHESIS
    a_clear_never_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.span_wr && !set_mode_reg |=> free_total_reg >= $past(free_total_reg))
        else $error("free count dropped while clearing frames");

    a_alloc_sets_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_set |=> ok_reg && (span_end_reg - span_first_reg == LIM_W'(cnt_reg)))
        else $error("allocated run does not match requested count");
`endif

endmodule

>>> sv/bfa_ctrl.sv
// Controller state machine of the bitmap frame allocator.
`timescale 1ns / 1ps

module bfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  bfa_pkg::bfa_sts_t sts,
    output bfa_pkg::bfa_cmd_t cmd
);
    import bfa_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:      if (sts.sweep_last) state_next = ST_IDLE;
            ST_IDLE:       if (in_valid) state_next = ST_SETUP;
            ST_SETUP:      state_next = ST_CLAMP;
            ST_CLAMP:      state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_INIT:
                        state_next = ST_INIT_SWEEP;
                    CMD_MARK_USABLE, CMD_MARK_RESERVED, CMD_FREE:
                        state_next = sts.span_empty ? ST_DONE : ST_SPAN_RD;
                    CMD_ALLOC:
                        state_next = sts.alloc_bad ? ST_DONE : ST_SCAN_RD;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_INIT_SWEEP: if (sts.sweep_last) state_next = ST_DONE;
            ST_SPAN_RD:    state_next = ST_SPAN_WR;
            ST_SPAN_WR:    state_next = sts.span_last ? ST_DONE : ST_SPAN_RD;
            ST_SCAN_RD:    state_next = ST_SCAN_BIT;
            ST_SCAN_BIT:
            begin
                if (sts.hit)
                begin
                    state_next = ST_ALLOC_SET;
                end
                else if (sts.stop)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.chunk_last)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_ALLOC_SET:  state_next = ST_SPAN_RD;
            ST_DONE:       if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR:      cmd.sweep_wr = 1'b1;
            ST_IDLE:       cmd.load_in  = in_valid;
            ST_SETUP:      cmd.setup    = 1'b1;
            ST_CLAMP:      cmd.clamp    = 1'b1;
            ST_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_INIT:
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.done_ok     = 1'b1;
                    end
                    CMD_MARK_USABLE, CMD_MARK_RESERVED, CMD_FREE:
                        cmd.done_ok = 1'b1;
                    CMD_ALLOC:
                        cmd.scan_start = !sts.alloc_bad;
                    default:
                        cmd.done_ok = 1'b0;
                endcase
            end
            ST_INIT_SWEEP: cmd.sweep_wr  = 1'b1;
            ST_SPAN_RD:    cmd.span_rd   = 1'b1;
            ST_SPAN_WR:    cmd.span_wr   = 1'b1;
            ST_SCAN_RD:    cmd.scan_rd   = 1'b1;
            ST_SCAN_BIT:   cmd.scan_step = 1'b1;
            ST_ALLOC_SET:  cmd.alloc_set = 1'b1;
            ST_DONE:       cmd.load_out  = out_free;
            default:       cmd.load_in   = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_word_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside completion");

    a_scan_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_BIT) |-> (sts.cmd == CMD_ALLOC))
        else $error("run scan entered for a command other than allocate");
`endif

endmodule

>>> sv/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: configuration register and wiring.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one command word: command, base_address,
//   length_bytes, frame_count. Output channel (out_valid/out_stall) returns one result
//   word per command: frame_address, success, free_count, used_count.
//   cfg_valid/cfg_ready writes managed_frames; write it only while the block is idle.
//   One command is worked at a time; the next is taken as soon as the result is in the
//   output register, even while the receiver still stalls it.
// Work per command, with W = FRAME_COUNT/32 map words of 32 frames each:
//   init sweeps all W map words. Marks and free read and write each map word touched.
//   Allocate reads each map word scanned and scans it one 8-frame chunk a cycle, then
//   reads and writes each word of the claimed run; the result is then registered.
//   The pace is set by the single port of the map memory and the chunk scanner.
// Reset: managed_frames returns to its default; a clearing pass over all W map words
//   marks every frame used; input stalls until it ends. The free total resets to zero.
// A stalled result holds in the output register; the block then finishes at most one
//   more command and waits before loading its result.
`timescale 1ns / 1ps

module bitmap_frame_allocator #(
    parameter int FRAME_COUNT = bfa_pkg::DEF_FRAME_COUNT,
    parameter int FRAME_BYTES = bfa_pkg::DEF_FRAME_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bfa_pkg::CMD_W-1:0]      command,
    input  logic [bfa_pkg::ADDR_W-1:0]     base_address,
    input  logic [bfa_pkg::ADDR_W-1:0]     length_bytes,
    input  logic [bfa_pkg::CNT_W-1:0]      frame_count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bfa_pkg::OUT_ADDR_W-1:0] frame_address,
    output logic                           success,
    output logic [bfa_pkg::CNT_W-1:0]      free_count,
    output logic [bfa_pkg::CNT_W-1:0]      used_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bfa_pkg::CFG_W-1:0]      cfg_data
);
    import bfa_pkg::*;

    localparam int MF_MAX = (1 << CFG_W) - 1;
    localparam logic [CFG_W-1:0] MF_RESET =
        CFG_W'((FRAME_COUNT > MF_MAX) ? MF_MAX : FRAME_COUNT);

    logic [CFG_W-1:0] managed_reg;
    bfa_cmd_t         cmd;
    bfa_sts_t         sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            managed_reg <= MF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            managed_reg <= cfg_data;
        end
    end

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bfa_datapath #(
        .FRAME_COUNT (FRAME_COUNT),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .command        (command),
        .base_address   (base_address),
        .length_bytes   (length_bytes),
        .frame_count    (frame_count),
        .managed_frames (managed_reg),
        .frame_address  (frame_address),
        .success        (success),
        .free_count     (free_count),
        .used_count     (used_count)
    );

endmodule

>>> bench/bitmap_frame_allocator_tb.sv
// Self-checking testbench of the bitmap frame allocator: directed, random and stall tests.
`timescale 1ns / 1ps

module bitmap_frame_allocator_tb;

    import bfa_pkg::*;

    localparam int        MAP_FRAMES  = DEF_FRAME_COUNT;
    localparam longint    PAGE        = DEF_FRAME_BYTES;
    localparam longint    ADDR_MASK   = 64'hFFFF_FFFF_FFFF;
    localparam longint    CYCLE_LIMIT = 20_000_000;
    localparam logic [CMD_W-1:0] CMD_BAD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BAD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_BAD7 = 3'd7;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] frame_address;
        logic                  success;
        logic [CNT_W-1:0]      free_count;
        logic [CNT_W-1:0]      used_count;
    } alloc_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [CMD_W-1:0]      command;
    logic [ADDR_W-1:0]     base_address;
    logic [ADDR_W-1:0]     length_bytes;
    logic [CNT_W-1:0]      frame_count;
    logic                  out_valid;
    logic                  out_stall;
    logic [OUT_ADDR_W-1:0] frame_address;
    logic                  success;
    logic [CNT_W-1:0]      free_count;
    logic [CNT_W-1:0]      used_count;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;

    // Mirror of the allocator state
    bit                    frame_used [MAP_FRAMES];
    int                    shadow_free;
    int                    frame_limit_reg;

    alloc_result_t         pending_results [$];
    int                    send_idle_pct;
    int                    stall_pct;
    int                    hold_left;
    int                    mismatches;
    int                    words_sent;
    int                    words_checked;
    int                    allocs_granted;
    longint                cycles;

    bitmap_frame_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .base_address  (base_address),
        .length_bytes  (length_bytes),
        .frame_count   (frame_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_address (frame_address),
        .success       (success),
        .free_count    (free_count),
        .used_count    (used_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("bitmap_frame_allocator regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
    end

    function automatic int effective_limit();
        return (frame_limit_reg < MAP_FRAMES) ? frame_limit_reg : MAP_FRAMES;
    endfunction

    function automatic void set_frame(longint unsigned idx, bit used);
        if (idx >= longint'(effective_limit()))
            return;
        if (used && !frame_used[idx])
        begin
            frame_used[idx] = 1'b1;
            shadow_free--;
        end
        else if (!used && frame_used[idx])
        begin
            frame_used[idx] = 1'b0;
            shadow_free++;
        end
    endfunction

    function automatic void set_span(longint unsigned first, longint unsigned last_excl,
                                     bit used);
        longint unsigned stop;
        stop = (last_excl < longint'(effective_limit())) ? last_excl : effective_limit();
        for (longint unsigned i = first; i < stop; i++)
            set_frame(i, used);
    endfunction

    // Apply one command word to the mirror and return the word the block must produce
    function automatic alloc_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                    longint unsigned base,
                                                    longint unsigned len,
                                                    int cnt);
        alloc_result_t   res;
        longint unsigned top;
        longint unsigned run;
        longint unsigned start;
        int              lim;
        res = '0;
        top = base + len;
        lim = effective_limit();
        case (cmd)
            CMD_INIT:
            begin
                foreach (frame_used[i])
                    frame_used[i] = 1'b1;
                shadow_free = 0;
                res.success = 1'b1;
            end
            CMD_MARK_USABLE:
            begin
                set_span((base + PAGE - 1) / PAGE, top / PAGE, 1'b0);
                res.success = 1'b1;
            end
            CMD_MARK_RESERVED:
            begin
                set_span(base / PAGE, (top + PAGE - 1) / PAGE, 1'b1);
                res.success = 1'b1;
            end
            CMD_ALLOC:
            begin
                run = 0;
                if (cnt != 0 && cnt <= lim)
                begin
                    for (int i = 0; i < lim; i++)
                    begin
                        run = frame_used[i] ? 0 : run + 1;
                        if (run == cnt)
                        begin
                            start = i + 1 - cnt;
                            for (longint unsigned j = start; j <= i; j++)
                                set_frame(j, 1'b1);
                            res.frame_address = OUT_ADDR_W'(start * PAGE);
                            res.success = 1'b1;
                            allocs_granted++;
                            break;
                        end
                    end
                end
            end
            CMD_FREE:
            begin
                start = base / PAGE;
                for (int i = 0; i < cnt; i++)
                    set_frame(start + i, 1'b0);
                res.success = 1'b1;
            end
            default: ;
        endcase
        lim = effective_limit();
        res.free_count = CNT_W'(shadow_free);
        res.used_count = (lim > shadow_free) ? CNT_W'(lim - shadow_free) : '0;
        return res;
    endfunction

    // Offer one word, hold it until taken, then idle the input at random
    task automatic send_word(logic [CMD_W-1:0] cmd, longint unsigned base,
                             longint unsigned len, int cnt);
        in_valid     <= 1'b1;
        command      <= cmd;
        base_address <= base[ADDR_W-1:0];
        length_bytes <= len[ADDR_W-1:0];
        frame_count  <= cnt[CNT_W-1:0];
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(apply_command(cmd, base & ADDR_MASK, len & ADDR_MASK,
                                                cnt & 13'h1FFF));
        words_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (out_valid && !out_stall)
        begin
            words_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word addr=%h ok=%b free=%0d used=%0d",
                             frame_address, success, free_count, used_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (frame_address !== want.frame_address || success !== want.success ||
                    free_count !== want.free_count || used_count !== want.used_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: want %h/%b/%0d/%0d got %h/%b/%0d/%0d",
                                 words_checked, want.frame_address, want.success,
                                 want.free_count, want.used_count, frame_address, success,
                                 free_count, used_count);
                end
            end
        end
    end

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value[CFG_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        frame_limit_reg = value & 13'h1FFF;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic longint unsigned rand_addr();
        longint unsigned a;
        if ($urandom_range(99) < 6)
            a = {$urandom, $urandom} & ADDR_MASK;
        else
            a = $urandom_range(24'hFFFFFF);
        return a;
    endfunction

    function automatic longint unsigned rand_len(longint unsigned base);
        longint unsigned l;
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            l = $urandom_range(20 * PAGE);
        else if (pick < 90)
            l = $urandom_range(24'hFFFFFF);
        else
            l = {$urandom, $urandom} & ADDR_MASK;
        // keep base plus length inside the 48-bit space
        if (l > ADDR_MASK - base)
            l = ADDR_MASK - base;
        return l;
    endfunction

    function automatic int rand_count();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return $urandom_range(1, 16);
        else if (pick < 93)
            return $urandom_range(0, 300);
        return $urandom_range(13'h1FFF);
    endfunction

    task automatic test_directed();
        send_word(CMD_ALLOC, 0, 0, 1);
        send_word(CMD_INIT, 0, 0, 0);
        send_word(CMD_MARK_USABLE, 0, 0, 0);
        send_word(CMD_MARK_USABLE, 100, 24'hFFFFFF, 0);
        send_word(CMD_ALLOC, 0, 0, 0);
        send_word(CMD_ALLOC, 0, 0, 1);
        send_word(CMD_ALLOC, 0, 0, 13'h1FFF);
        send_word(CMD_ALLOC, 0, 0, MAP_FRAMES);
        send_word(CMD_FREE, 0, 0, 0);
        send_word(CMD_FREE, 0, 0, MAP_FRAMES);
        send_word(CMD_ALLOC, 0, 0, MAP_FRAMES);
        send_word(CMD_MARK_RESERVED, 4095, 2, 0);
        send_word(CMD_MARK_RESERVED, ADDR_MASK, 0, 0);
        send_word(CMD_MARK_USABLE, ADDR_MASK - 8191, 8191, 0);
        send_word(CMD_FREE, ADDR_MASK, 0, 13'h1FFF);
        send_word(CMD_ALLOC, 0, 0, 2);
        send_word(CMD_BAD5, ADDR_MASK, ADDR_MASK, 13'h1FFF);
        send_word(CMD_BAD6, 0, 0, 1);
        send_word(CMD_BAD7, 12345, 1, 3);
        send_word(CMD_FREE, 24'hFFF000, 0, 13'h1FFF);
        send_word(CMD_ALLOC, 0, 0, 1);
        drain_results();
    endtask

    // Shrink and widen the limit around marked frames, including zero and one
    task automatic test_limits();
        write_limit(0);
        send_word(CMD_MARK_USABLE, 0, 24'hFFFFFF, 0);
        send_word(CMD_ALLOC, 0, 0, 1);
        write_limit(1);
        send_word(CMD_MARK_USABLE, 0, 24'hFFFFFF, 0);
        send_word(CMD_ALLOC, 0, 0, 1);
        send_word(CMD_ALLOC, 0, 0, 1);
        write_limit(8191);
        send_word(CMD_MARK_USABLE, 0, 24'hFFFFFF, 0);
        write_limit(37);
        send_word(CMD_ALLOC, 0, 0, 40);
        send_word(CMD_ALLOC, 0, 0, 5);
        send_word(CMD_MARK_RESERVED, 0, 24'hFFFFFF, 0);
        write_limit(MAP_FRAMES);
        send_word(CMD_ALLOC, 0, 0, 3);
    endtask

    task automatic test_random_phase(int limit, int idle_pct, int stall_rate, int words);
        logic [CMD_W-1:0] cmd;
        longint unsigned  base;
        int               pick;
        write_limit(limit);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        send_word(CMD_INIT, 0, 0, 0);
        send_word(CMD_MARK_USABLE, PAGE, 24'hFFFFFF - PAGE, 0);
        for (int n = 0; n < words; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                cmd = CMD_INIT;
            else if (pick < 14)
                cmd = CMD_MARK_USABLE;
            else if (pick < 22)
                cmd = CMD_MARK_RESERVED;
            else if (pick < 62)
                cmd = CMD_ALLOC;
            else if (pick < 96)
                cmd = CMD_FREE;
            else
            begin
                case ($urandom_range(2))
                    0:       cmd = CMD_BAD5;
                    1:       cmd = CMD_BAD6;
                    default: cmd = CMD_BAD7;
                endcase
            end
            base = rand_addr();
            send_word(cmd, base, rand_len(base), rand_count());
            if (cmd == CMD_INIT)
                send_word(CMD_MARK_USABLE, 0, $urandom_range(24'hFFFFFF), 0);
        end
        drain_results();
    endtask

    // Stall the output for a long stretch so the block backs up into its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 1500;
        for (int n = 0; n < 12; n++)
            send_word(CMD_ALLOC, 0, 0, $urandom_range(1, 4));
        drain_results();
        for (int n = 0; n < 8; n++)
            send_word(CMD_FREE, $urandom_range(24'hFFFFFF), 0, $urandom_range(1, 8));
        drain_results();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        command         = CMD_INIT;
        base_address    = '0;
        length_bytes    = '0;
        frame_count     = '0;
        out_stall       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        cycles          = 0;
        hold_left       = 0;
        mismatches      = 0;
        words_sent      = 0;
        words_checked   = 0;
        allocs_granted  = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        shadow_free     = 0;
        frame_limit_reg = MAP_FRAMES;
        foreach (frame_used[i])
            frame_used[i] = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limits();
        test_random_phase(MAP_FRAMES, 0, 0, 420);
        test_random_phase(8191, 69, 0, 400);
        test_random_phase(2000, 0, 69, 400);
        test_random_phase(MAP_FRAMES, 24, 24, 400);
        test_backpressure();

        drain_results();
        repeat (40) @(posedge clk);
        $display("covered %0d command words, %0d result words, %0d granted allocations",
                 words_sent, words_checked, allocs_granted);
        $display("limits 0 to 8191, idle and stall mixes, long output hold; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("bitmap_frame_allocator regression: pass");
        else
            $display("bitmap_frame_allocator regression: fail");
        $finish;
    end

endmodule
